FILE: hw/rtl/htpc_pkg.sv
// htpc_pkg: shared types and codes for the heater thermostat pwm controller
// beat structs for the input and result channels, config register group,
// event codes and register indexes; no dependencies
package htpc_pkg;

  // event codes carried in req_type
  localparam logic [1:0] REQ_MINUTE = 2'd0;
  localparam logic [1:0] REQ_SECOND = 2'd1;
  localparam logic [1:0] REQ_EXPIRY = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_DELAY_MIN    = 3'd0;
  localparam logic [2:0] CFG_FAULT_ON     = 3'd1;
  localparam logic [2:0] CFG_FAULT_OFF    = 3'd2;
  localparam logic [2:0] CFG_SET_TEMP     = 3'd3;
  localparam logic [2:0] CFG_HYSTERESIS   = 3'd4;
  localparam logic [2:0] CFG_FULL_BAND    = 3'd5;
  localparam logic [2:0] CFG_DUTY_PERCENT = 3'd6;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [6:0] DUTY_MAX   = 7'd100;
  localparam logic [6:0] DUTY_RESET = 7'd25;
  localparam logic [5:0] SEC_PER_MIN = 6'd60;

  // one input beat
  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] temperature;
    logic               door_open;
    logic               sensor_fault;
  } in_item_t;

  // one result beat
  typedef struct packed {
    logic        heater_enabled;
    logic        pwm_active;
    logic        drive_level;
    logic        reload_valid;
    logic [15:0] reload_count;
  } out_item_t;

  // configuration register group
  typedef struct packed {
    logic [7:0]         delay_minutes;
    logic [7:0]         fault_on_minutes;
    logic [7:0]         fault_off_minutes;
    logic signed [15:0] set_temperature;
    logic [14:0]        hysteresis;
    logic [14:0]        full_power_band;
    logic [6:0]         duty_percent;
  } cfg_regs_t;

endpackage

FILE: hw/rtl/htpc_ctl.sv
// htpc_ctl: controller state and single-pass event evaluation
// holds delay, fault timer, thermostat and pwm state; depends on htpc_pkg
module htpc_ctl import htpc_pkg::*; #(
  parameter int unsigned PWM_PERIOD_COUNTS = 33333
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  in_item_t  item,
  input  cfg_regs_t cfg,
  output out_item_t result
);

  // high-phase counts for every duty value, built at elaboration
  function automatic logic [100:0][15:0] build_hi_tab();
    logic [100:0][15:0] tab;
    for (int d = 0; d <= 100; d++) begin
      tab[d] = 16'((PWM_PERIOD_COUNTS * d) / 100);
    end
    return tab;
  endfunction

  localparam logic [100:0][15:0] HI_TAB = build_hi_tab();
  localparam logic [15:0] PERIOD = 16'(PWM_PERIOD_COUNTS);

  logic        delay_active_r, delay_active_nxt;
  logic [7:0]  dly_cnt_r, dly_cnt_nxt;
  logic [15:0] flt_cnt_r, flt_cnt_nxt;
  logic        heater_on_r, heater_on_nxt;
  logic        pwm_mode_r, pwm_mode_nxt;
  logic        phase_hi_r, phase_hi_nxt;
  logic        drive_r, drive_nxt;

  logic [7:0]         dly_inc;
  logic [15:0]        flt_inc;
  logic [7:0]         flt_min;
  logic [13:0]        flt_limit;
  logic signed [17:0] temp_x;
  logic signed [17:0] off_thr;
  logic signed [17:0] on_thr;
  logic signed [16:0] deficit;
  logic [6:0]         duty_sat;
  logic [15:0]        hi_cnt;
  logic [15:0]        lo_cnt;
  logic               rvalid;
  logic [15:0]        rcount;
  logic               want_pwm;

  // shared arithmetic
  always_comb begin
    dly_inc   = dly_cnt_r + 8'd1;
    flt_inc   = flt_cnt_r + 16'd1;
    flt_min   = heater_on_r ? cfg.fault_on_minutes : cfg.fault_off_minutes;
    flt_limit = {6'd0, flt_min} * {8'd0, SEC_PER_MIN};
    temp_x    = 18'(item.temperature);
    off_thr   = 18'(cfg.set_temperature) + $signed({3'b000, cfg.hysteresis});
    on_thr    = 18'(cfg.set_temperature) - $signed({3'b000, cfg.hysteresis});
    duty_sat  = (cfg.duty_percent > DUTY_MAX) ? DUTY_MAX : cfg.duty_percent;
    hi_cnt    = HI_TAB[duty_sat];
    lo_cnt    = PERIOD - hi_cnt;
  end

  // event evaluation and drive stage
  always_comb begin
    delay_active_nxt = delay_active_r;
    dly_cnt_nxt      = dly_cnt_r;
    flt_cnt_nxt      = flt_cnt_r;
    heater_on_nxt    = heater_on_r;
    phase_hi_nxt     = phase_hi_r;
    drive_nxt        = drive_r;
    rvalid           = 1'b0;
    rcount           = 16'd0;
    case (item.req_type)
      REQ_MINUTE: begin
        if (delay_active_r) begin
          if (dly_inc >= cfg.delay_minutes) begin
            dly_cnt_nxt      = 8'd0;
            delay_active_nxt = 1'b0;
          end else begin
            dly_cnt_nxt = dly_inc;
          end
        end
      end
      REQ_SECOND: begin
        if (!delay_active_r) begin
          if (item.door_open) begin
            heater_on_nxt = 1'b0;
          end else if (item.sensor_fault) begin
            if (flt_inc >= {2'b00, flt_limit}) begin
              flt_cnt_nxt   = 16'd0;
              heater_on_nxt = !heater_on_r;
            end else begin
              flt_cnt_nxt = flt_inc;
            end
          end else if (heater_on_r) begin
            if (temp_x >= off_thr) heater_on_nxt = 1'b0;
          end else begin
            if (temp_x <= on_thr) heater_on_nxt = 1'b1;
          end
        end
      end
      REQ_EXPIRY: begin
        if (pwm_mode_r) begin
          phase_hi_nxt = !phase_hi_r;
          rcount       = phase_hi_nxt ? hi_cnt : lo_cnt;
          drive_nxt    = phase_hi_nxt;
          rvalid       = 1'b1;
        end
      end
      default: begin
      end
    endcase

    deficit  = 17'(cfg.set_temperature) - 17'(item.temperature);
    want_pwm = heater_on_nxt && (deficit < $signed({2'b00, cfg.full_power_band}));
    if (!heater_on_nxt) begin
      drive_nxt    = 1'b0;
      pwm_mode_nxt = 1'b0;
    end else if (!want_pwm) begin
      drive_nxt    = 1'b1;
      pwm_mode_nxt = 1'b0;
    end else begin
      pwm_mode_nxt = 1'b1;
    end

    result.heater_enabled = heater_on_nxt;
    result.pwm_active     = pwm_mode_nxt;
    result.drive_level    = drive_nxt;
    result.reload_valid   = rvalid;
    result.reload_count   = rcount;
  end

  // state registers, advanced once per beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_active_r <= 1'b1;
      dly_cnt_r      <= 8'd0;
      flt_cnt_r      <= 16'd0;
      heater_on_r    <= 1'b0;
      pwm_mode_r     <= 1'b0;
      phase_hi_r     <= 1'b0;
      drive_r        <= 1'b0;
    end else if (step_en) begin
      delay_active_r <= delay_active_nxt;
      dly_cnt_r      <= dly_cnt_nxt;
      flt_cnt_r      <= flt_cnt_nxt;
      heater_on_r    <= heater_on_nxt;
      pwm_mode_r     <= pwm_mode_nxt;
      phase_hi_r     <= phase_hi_nxt;
      drive_r        <= drive_nxt;
    end
  end

  // pwm only runs with the heater demanded on
  a_pwm_needs_heater: assert property (@(posedge clk) disable iff (!rst_n)
    pwm_mode_r |-> heater_on_r)
    else $error("pwm running with heater off");

  // element never conducts with the heater off
  a_drive_needs_heater: assert property (@(posedge clk) disable iff (!rst_n)
    drive_r |-> heater_on_r)
    else $error("element driven with heater off");

  // heater stays off through the power-on delay
  a_delay_holds_off: assert property (@(posedge clk) disable iff (!rst_n)
    delay_active_r |-> !heater_on_r && !pwm_mode_r)
    else $error("heater on during power-on delay");

endmodule

FILE: hw/rtl/heater_thermostat_pwm_controller_unit.sv
// heater_thermostat_pwm_controller_unit: top level of the heater controller
// input register, config registers, htpc_ctl and a two-entry result buffer;
// depends on htpc_pkg and htpc_ctl
//
//   channel | ports                          | beat
//   --------+--------------------------------+-----------------------------
//   input   | in_valid, in_stall, in_data    | one event (in_item_t)
//   result  | out_valid, out_stall, out_data | one result (out_item_t)
//   config  | cfg_we, cfg_idx, cfg_wdata     | one register write
//
// each event gives one result: it waits in the input register, then the
// controller logic writes the result buffer once the skid entry is free.
// one event per cycle is taken while the result side keeps up; the skid entry
// of the result buffer lets an event enter while a finished result waits.
// in_stall rises only when the input register holds an event and both result
// entries are full. synchronous reset restores the power-on delay state.
module heater_thermostat_pwm_controller_unit import htpc_pkg::*; #(
  parameter int unsigned PWM_PERIOD_COUNTS = 33333
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_regs_t cfg_r;
  logic      in_vld_r;
  in_item_t  in_r;
  logic      out_vld_r;
  out_item_t out_r;
  logic      skd_vld_r;
  out_item_t skd_r;
  out_item_t res;
  logic      adv;
  logic      in_acc;
  logic      pop;

  assign in_acc    = in_valid && !in_stall;
  assign adv       = in_vld_r && !skd_vld_r;
  assign in_stall  = in_vld_r && skd_vld_r;
  assign pop       = out_vld_r && !out_stall;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay_minutes     <= 8'd0;
      cfg_r.fault_on_minutes  <= 8'd0;
      cfg_r.fault_off_minutes <= 8'd0;
      cfg_r.set_temperature   <= 16'sd0;
      cfg_r.hysteresis        <= 15'd0;
      cfg_r.full_power_band   <= 15'd0;
      cfg_r.duty_percent      <= DUTY_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_DELAY_MIN:    cfg_r.delay_minutes     <= cfg_wdata[7:0];
        CFG_FAULT_ON:     cfg_r.fault_on_minutes  <= cfg_wdata[7:0];
        CFG_FAULT_OFF:    cfg_r.fault_off_minutes <= cfg_wdata[7:0];
        CFG_SET_TEMP:     cfg_r.set_temperature   <= $signed(cfg_wdata);
        CFG_HYSTERESIS:   cfg_r.hysteresis        <= cfg_wdata[14:0];
        CFG_FULL_BAND:    cfg_r.full_power_band   <= cfg_wdata[14:0];
        CFG_DUTY_PERCENT: cfg_r.duty_percent      <= cfg_wdata[6:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= in_data;
    end
  end

  // controller state and event logic
  htpc_ctl #(
    .PWM_PERIOD_COUNTS(PWM_PERIOD_COUNTS)
  ) u_ctl (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(adv),
    .item   (in_r),
    .cfg    (cfg_r),
    .result (res)
  );

  // result buffer: output entry plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      skd_vld_r <= 1'b0;
    end else if (pop) begin
      if (skd_vld_r) begin
        out_vld_r <= 1'b1;
        skd_vld_r <= adv;
      end else begin
        out_vld_r <= adv;
      end
    end else if (!out_vld_r) begin
      out_vld_r <= adv;
    end else if (adv) begin
      skd_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skd_vld_r) begin
        out_r <= skd_r;
        if (adv) skd_r <= res;
      end else if (adv) begin
        out_r <= res;
      end
    end else if (!out_vld_r) begin
      if (adv) out_r <= res;
    end else if (adv) begin
      skd_r <= res;
    end
  end

  // skid entry only fills behind a full output entry
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skd_vld_r |-> out_vld_r)
    else $error("skid entry valid with output entry empty");

  // skid fills only when the output entry was held
  a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skd_vld_r) |-> $past(out_vld_r && out_stall))
    else $error("skid entry filled while output entry was free");

  // a result without a reload carries a zero count
  a_no_reload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_r.reload_valid |-> out_r.reload_count == 16'd0)
    else $error("reload count set without reload");

endmodule
